### src/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants for the record bubble sorter.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int unsigned MAX_RECORDS_DEF = 64;
  localparam int unsigned KEY_BITS_DEF    = 64;
  localparam int unsigned PORT_KEY_W      = 64;
  localparam int unsigned TAG_W           = 8;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_FETCH,
    ST_SWEEP,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic fetch;
    logic sweep;
  } sort_ctl_t;

endpackage

### src/rbs_ram.sv
// ----------------------------------------------------------------------------
// rbs_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/rbs_sort_dp.sv
// ----------------------------------------------------------------------------
// rbs_sort_dp
// Bubble carry register with key compare; picks the word to write back.
// ----------------------------------------------------------------------------
module rbs_sort_dp
  import rbs_pkg::*;
#(
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic                      clk,
  input  sort_ctl_t                 ctl,
  input  logic                      key_signed,
  input  logic [KEY_BITS+TAG_W-1:0] rd_data,
  output logic [KEY_BITS+TAG_W-1:0] carry_data,
  output logic [KEY_BITS+TAG_W-1:0] wr_data
);

  localparam logic [KEY_BITS-1:0] SIGN_MASK = {1'b1, {(KEY_BITS-1){1'b0}}};

  logic [KEY_BITS+TAG_W-1:0] carry_r;
  logic [KEY_BITS+TAG_W-1:0] carry_nxt;
  logic [KEY_BITS-1:0]       flip;
  logic [KEY_BITS-1:0]       key_a;
  logic [KEY_BITS-1:0]       key_b;
  logic                      greater;

  always_comb begin
    flip    = key_signed ? SIGN_MASK : '0;
    key_a   = carry_r[KEY_BITS-1:0] ^ flip;
    key_b   = rd_data[KEY_BITS-1:0] ^ flip;
    greater = key_a > key_b;
    wr_data = greater ? rd_data : carry_r;
    carry_nxt = carry_r;
    if (ctl.fetch) begin
      carry_nxt = rd_data;
    end else if (ctl.sweep && !greater) begin
      carry_nxt = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
  end

  assign carry_data = carry_r;

endmodule

### src/record_bubble_sorter_unit.sv
// ----------------------------------------------------------------------------
// record_bubble_sorter_unit
// Collects records into a RAM, bubble sorts them in place and streams them.
// Load: one record per cycle while busy is low.
// Sort: starts after the last record; a prep step, then passes of m compares,
//   each a fetch, m sweeps and a flush, over one RAM read port.
// Output: n words on consecutive cycles, registered, starting after the sort;
//   the receiver cannot stall, busy drops with the final word.
// Reset (synchronous, rst_n low): empties the set, clears key_signed.
// ----------------------------------------------------------------------------
module record_bubble_sorter_unit
  import rbs_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [PORT_KEY_W-1:0] in_sort_key,
  input  logic [TAG_W-1:0]      in_record_tag,
  input  logic                  in_last_record,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_key_signed,
  output logic                  out_valid,
  output logic [PORT_KEY_W-1:0] out_sorted_key,
  output logic [TAG_W-1:0]      out_sorted_tag,
  output logic                  out_last_out,
  output logic                  out_overflow
);

  localparam int unsigned AW = $clog2(MAX_RECORDS);
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned W  = KEY_BITS + TAG_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_RECORDS);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            dropped_r, dropped_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   lim_r, lim_nxt;
  logic            key_signed_r;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [W-1:0]    wr_data;
  logic [AW-1:0]   rd_addr;
  logic [W-1:0]    rd_data;
  logic [W-1:0]    carry_data;
  logic [W-1:0]    dp_wr_data;
  sort_ctl_t       ctl;
  logic            emit;
  logic            last_emit;

  logic                  out_valid_r;
  logic [PORT_KEY_W-1:0] out_key_r;
  logic [TAG_W-1:0]      out_tag_r;
  logic                  out_last_r;
  logic                  out_ovf_r;

  rbs_ram #(
    .WIDTH (W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (1'b1),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rbs_sort_dp #(
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .ctl        (ctl),
    .key_signed (key_signed_r),
    .rd_data    (rd_data),
    .carry_data (carry_data),
    .wr_data    (dp_wr_data)
  );

  assign last_emit = (CW'(idx_r) == count_r - CW'(1));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    idx_nxt     = idx_r;
    lim_nxt     = lim_r;
    wr_en       = 1'b0;
    wr_addr     = count_r[AW-1:0];
    wr_data     = {in_record_tag, in_sort_key[KEY_BITS-1:0]};
    rd_addr     = '0;
    ctl         = '0;
    emit        = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          if (count_r != FULL) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last_record) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        idx_nxt = '0;
        lim_nxt = AW'(count_r - CW'(1));
        state_nxt = (count_r > CW'(1)) ? ST_FETCH : ST_EMIT;
      end
      ST_FETCH: begin
        ctl.fetch = 1'b1;
        rd_addr   = AW'(1);
        idx_nxt   = AW'(1);
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        ctl.sweep = 1'b1;
        wr_en     = 1'b1;
        wr_addr   = idx_r - AW'(1);
        wr_data   = dp_wr_data;
        if (idx_r == lim_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          rd_addr = idx_r + AW'(1);
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_FLUSH: begin
        wr_en   = 1'b1;
        wr_addr = lim_r;
        wr_data = carry_data;
        idx_nxt = '0;
        if (lim_r == AW'(1)) begin
          state_nxt = ST_EMIT;
        end else begin
          lim_nxt   = lim_r - AW'(1);
          state_nxt = ST_FETCH;
        end
      end
      ST_EMIT: begin
        emit    = 1'b1;
        rd_addr = idx_r + AW'(1);
        idx_nxt = idx_r + AW'(1);
        if (last_emit) begin
          state_nxt   = ST_LOAD;
          count_nxt   = '0;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      dropped_r    <= 1'b0;
      idx_r        <= '0;
      lim_r        <= '0;
      key_signed_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      idx_r       <= idx_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= emit;
      if (cfg_valid && cfg_ready) begin
        key_signed_r <= cfg_key_signed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_key_r  <= PORT_KEY_W'(rd_data[KEY_BITS-1:0]);
      out_tag_r  <= rd_data[KEY_BITS +: TAG_W];
      out_last_r <= last_emit;
      out_ovf_r  <= dropped_r;
    end
  end

  assign busy           = (state_r != ST_LOAD);
  assign cfg_ready      = (state_r == ST_LOAD);
  assign out_valid      = out_valid_r;
  assign out_sorted_key = out_key_r;
  assign out_sorted_tag = out_tag_r;
  assign out_last_out   = out_last_r;
  assign out_overflow   = out_ovf_r;

endmodule

### src/rbs_checker.sv
// ----------------------------------------------------------------------------
// rbs_checker
// Port-level checks on the sorter's command and result sequencing.
// ----------------------------------------------------------------------------
module rbs_checker
  import rbs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_last_record,
  input logic                  out_valid,
  input logic                  out_last_out
);

  ast_mid_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy || out_last_out))
    else $error("non-final word while idle");

  ast_final_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_out) |-> !busy)
    else $error("still busy at final word");

  ast_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_out) |=> out_valid)
    else $error("gap in result stream");

  ast_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_record) |=> (busy && !out_valid))
    else $error("last record did not start sort");

  ast_plain_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_record) |=> (!busy && !out_valid))
    else $error("word after non-last record");

endmodule

bind record_bubble_sorter_unit rbs_checker u_rbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_last_record (in_last_record),
  .out_valid      (out_valid),
  .out_last_out   (out_last_out)
);
